// ===== hdl/slt_pkg.sv =====
// ----------------------------------------------------------------------------
// slt_pkg: shared types and constants for the sorted list table
// Holds the table depth, the derived counter widths, the action codes and the
// control bundle that the top level broadcasts to every cell.
// ----------------------------------------------------------------------------
package slt_pkg;

    localparam int DEPTH   = 16;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int KEY_W   = 32;
    localparam int POS_W   = 5;
    localparam int OUT_W   = 16;
    localparam int ACT_W   = 2;

    typedef enum logic [ACT_W-1:0] {
        ACT_INSERT = 2'd0,
        ACT_DELETE = 2'd1,
        ACT_LOOKUP = 2'd2,
        ACT_CLEAR  = 2'd3
    } action_t;

    // Broadcast to every cell for one transaction.
    typedef struct packed {
        logic ins_en;   // insert that fits
        logic del_en;   // delete whose key is present
    } slt_ctrl_t;

endpackage

// ===== hdl/slt_cell.sv =====
// ----------------------------------------------------------------------------
// slt_cell: one slot of the sorted table
// Holds one value, compares it against the broadcast key and takes its
// neighbor's value when an insert shifts up or a delete shifts down.
// ----------------------------------------------------------------------------
module slt_cell (
    input  logic                             aclk,
    input  slt_pkg::slt_ctrl_t               ctrl,
    input  logic signed [slt_pkg::KEY_W-1:0] key,
    input  logic                             occ,       // slot holds a live value
    input  logic                             at_tail,   // first free slot
    input  logic                             prev_gt,
    input  logic signed [slt_pkg::KEY_W-1:0] prev_val,
    input  logic signed [slt_pkg::KEY_W-1:0] next_val,
    output logic signed [slt_pkg::KEY_W-1:0] val,
    output logic                             gt,
    output logic                             eq
);
    import slt_pkg::*;

    logic signed [KEY_W-1:0] val_reg;
    logic signed [KEY_W-1:0] val_next;

    assign val = val_reg;
    assign gt  = occ && (val_reg > key);
    assign eq  = occ && (val_reg == key);

    // Insert: every slot above the key moves up one place, and the slot where
    // the run of larger values starts (or the tail) takes the key itself.
    // Delete: from the first match onward every live slot takes its upper
    // neighbor's value.
    always_comb begin
        val_next = val_reg;
        if (ctrl.ins_en && (gt || at_tail)) begin
            val_next = prev_gt ? prev_val : key;
        end else if (ctrl.del_en && (eq || gt)) begin
            val_next = next_val;
        end
    end

    always_ff @(posedge aclk) begin
        val_reg <= val_next;
    end

endmodule

// ===== hdl/sorted_list_table_top.sv =====
// ----------------------------------------------------------------------------
// sorted_list_table_top: ordered table of signed values in a chain of cells
// Keeps up to DEPTH values in ascending order and answers insert, delete,
// lookup and clear transactions, one result per transaction.
// ----------------------------------------------------------------------------
// The result of a transaction is on m_tvalid in the cycle after it is
// accepted; the compare in every cell and the shift happen in the accept cycle.
// Throughput: one transaction per cycle, limited only by the output register.
// A new transaction is taken while the output register is empty or is being
// drained in the same cycle.
// Reset (aresetn low, synchronous) empties the table and the output register;
// the cell contents are left as they are and become visible only when written.
// ----------------------------------------------------------------------------
module sorted_list_table_top (
    input  logic                         aclk,
    input  logic                         aresetn,
    // Input channel.
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [slt_pkg::KEY_W-1:0]    s_tdata,   // [31:0] key_value (signed)
    input  logic [slt_pkg::ACT_W-1:0]    s_tuser,   // [1:0] action
    // Result channel.
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // [4:0] position, [9:5] count, [10] empty flag, [11] full flag,
    // [12] overflow, [15:13] zero
    output logic [slt_pkg::OUT_W-1:0]    m_tdata
);
    import slt_pkg::*;

    // ------------------------------------------------------------------
    // Handshake. The output register parts the two sides, so a waiting
    // result does not stop a new transaction if it leaves in this cycle.
    // ------------------------------------------------------------------
    logic                accept;
    logic                m_tvalid_reg;
    logic                m_tvalid_next;
    logic [OUT_W-1:0]    m_tdata_reg;
    logic [OUT_W-1:0]    m_tdata_next;
    logic [CNT_W-1:0]    cnt_reg;
    logic [CNT_W-1:0]    cnt_next;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    logic signed [KEY_W-1:0] key;
    action_t                 action;

    assign key    = $signed(s_tdata);
    assign action = action_t'(s_tuser);

    // ------------------------------------------------------------------
    // The cell chain. Every cell compares its value with the key; since
    // the table is sorted, equal values sit side by side and the larger
    // values form one run at the top of the live part.
    // ------------------------------------------------------------------
    logic signed [KEY_W-1:0] vals [DEPTH];
    logic [DEPTH-1:0]        gt_vec;
    logic [DEPTH-1:0]        eq_vec;
    logic [DEPTH-1:0]        first_vec;
    slt_ctrl_t               ctrl;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic                    occ;
        logic                    at_tail;
        logic                    prev_gt;
        logic signed [KEY_W-1:0] prev_val;
        logic signed [KEY_W-1:0] next_val;

        assign occ     = CNT_W'(i) < cnt_reg;
        assign at_tail = CNT_W'(i) == cnt_reg;

        if (i == 0) begin : g_head
            assign prev_gt  = 1'b0;
            assign prev_val = key;
            assign first_vec[i] = eq_vec[i];
        end else begin : g_body
            assign prev_gt  = gt_vec[i-1];
            assign prev_val = vals[i-1];
            assign first_vec[i] = eq_vec[i] && !eq_vec[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign next_val = vals[i];
        end else begin : g_inner
            assign next_val = vals[i+1];
        end

        slt_cell u_cell (
            .aclk     (aclk),
            .ctrl     (ctrl),
            .key      (key),
            .occ      (occ),
            .at_tail  (at_tail),
            .prev_gt  (prev_gt),
            .prev_val (prev_val),
            .next_val (next_val),
            .val      (vals[i]),
            .gt       (gt_vec[i]),
            .eq       (eq_vec[i])
        );
    end

    // ------------------------------------------------------------------
    // Decode of the action and the fill count update.
    // ------------------------------------------------------------------
    logic             full;
    logic             found;
    logic             ovf;
    logic [POS_W-1:0] pos;

    assign full  = cnt_reg == CNT_W'(DEPTH);
    assign found = |eq_vec;

    // At most one cell flags the start of the matching run.
    always_comb begin
        pos = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (first_vec[i]) begin
                pos = pos | POS_W'(i + 1);
            end
        end
    end

    always_comb begin
        ctrl     = '0;
        ovf      = 1'b0;
        cnt_next = cnt_reg;
        unique case (action)
            ACT_INSERT: begin
                if (full) begin
                    ovf = 1'b1;
                end else begin
                    ctrl.ins_en = accept;
                    cnt_next    = cnt_reg + CNT_W'(1);
                end
            end
            ACT_DELETE: begin
                if (found) begin
                    ctrl.del_en = accept;
                    cnt_next    = cnt_reg - CNT_W'(1);
                end
            end
            ACT_LOOKUP: begin
                cnt_next = cnt_reg;
            end
            ACT_CLEAR: begin
                cnt_next = '0;
            end
            default: begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Result register.
    // ------------------------------------------------------------------
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (accept) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = '0;
            m_tdata_next[4:0]  = pos;
            m_tdata_next[9:5]  = POS_W'(cnt_next);
            m_tdata_next[10]   = cnt_next == '0;
            m_tdata_next[11]   = cnt_next == CNT_W'(DEPTH);
            m_tdata_next[12]   = ovf;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
            cnt_reg      <= '0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
            if (accept) begin
                cnt_reg <= cnt_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

endmodule

// ===== hdl/slt_checker.sv =====
// ----------------------------------------------------------------------------
// slt_checker: port-level checks for the sorted list table
// Watches the top level's ports and flags results that cannot belong
// together, plus the hold rule on a stalled result.
// ----------------------------------------------------------------------------
module slt_checker (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_tvalid,
    input logic                      s_tready,
    input logic [slt_pkg::ACT_W-1:0] s_tuser,
    input logic                      m_tvalid,
    input logic                      m_tready,
    input logic [slt_pkg::OUT_W-1:0] m_tdata
);
    import slt_pkg::*;

    // A dropped insert only happens on a full table, which stays full.
    a_ovf_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[12] |-> m_tdata[11])
        else $error("overflow reported on a table that is not full");

    // The empty flag agrees with the count.
    a_empty_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[10] == (m_tdata[9:5] == 5'd0)))
        else $error("empty flag disagrees with count");

    // A clear transaction leaves an empty table in its result.
    a_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == ACT_CLEAR)
        |=> m_tvalid && (m_tdata[9:5] == 5'd0) && m_tdata[10] && !m_tdata[12])
        else $error("clear did not empty the table");

    // A stalled result holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

endmodule

bind sorted_list_table_top slt_checker u_slt_checker (.*);
